@@ hdl/lsi_pkg.sv @@
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared status codes and queue status type for the line crossing block.
// ----------------------------------------------------------------------------
package lsi_pkg;

	localparam logic [1:0] ST_PARALLEL = 2'd0;
	localparam logic [1:0] ST_HIT      = 2'd1;
	localparam logic [1:0] ST_OUTSIDE  = 2'd2;

	typedef struct packed {
		logic full;
		logic empty;
	} lsi_qstat_t;

endpackage

@@ hdl/lsi_fifo.sv @@
// ----------------------------------------------------------------------------
// lsi_fifo
// Small register queue; DEPTH must be a power of two, at least 2.
// ----------------------------------------------------------------------------
module lsi_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr,
	input  logic [WIDTH-1:0]   wr_data,
	input  logic               rd,
	output logic [WIDTH-1:0]   rd_data,
	output lsi_pkg::lsi_qstat_t stat
);
	import lsi_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rd_data    = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= wp_q + 1'b1;
			if (do_rd)
				rp_q <= rp_q + 1'b1;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 1'b1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wp_q] <= wr_data;
	end

endmodule

@@ hdl/lsi_front.sv @@
// ----------------------------------------------------------------------------
// lsi_front
// Forms the direction vectors, the cross-product denominator and the two
// numerators, and classifies each item as parallel, hit or outside.
// ----------------------------------------------------------------------------
module lsi_front #(
	parameter int COORD_WIDTH = 32,
	localparam int W  = COORD_WIDTH,
	localparam int D  = W + 1,
	localparam int PP = 2 * D,
	localparam int P  = 2 * D + 1,
	localparam int FW = 3 + 2 * W + 2 * D + 2 * P
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_full,
	input  logic                mode,
	input  logic [W-1:0]        a_start_x,
	input  logic [W-1:0]        a_start_y,
	input  logic [W-1:0]        a_end_x,
	input  logic [W-1:0]        a_end_y,
	input  logic [W-1:0]        b_start_x,
	input  logic [W-1:0]        b_start_y,
	input  logic [W-1:0]        b_end_x,
	input  logic [W-1:0]        b_end_y,
	output logic                out_valid,
	input  logic                out_full,
	output logic [FW-1:0]       out_data
);
	import lsi_pkg::*;

	logic en;
	logic take;

	logic                v_s1, v_s2, v_s3;
	logic                mode_s1, mode_s2, mode_s3;
	logic [W-1:0]        a1x_s1, a1y_s1, a1x_s2, a1y_s2, a1x_s3, a1y_s3;
	logic signed [D-1:0] adx_s1, ady_s1, bdx_s1, bdy_s1, ox_s1, oy_s1;
	logic signed [D-1:0] adx_s2, ady_s2, adx_s3, ady_s3;
	logic signed [PP-1:0] pd0_s2, pd1_s2, pl0_s2, pl1_s2, pm0_s2, pm1_s2;
	logic signed [P-1:0] den_s3, lam_s3, mu_s3;

	logic       par;
	logic       lam_in;
	logic       mu_in;
	logic [1:0] status;

	// hold every stage while the last one waits on a full queue
	assign en        = !(v_s3 && out_full);
	assign in_full   = !en;
	assign take      = in_valid && en;
	assign out_valid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			a1x_s1  <= a_start_x;
			a1y_s1  <= a_start_y;
			adx_s1  <= {a_end_x[W-1], a_end_x} - {a_start_x[W-1], a_start_x};
			ady_s1  <= {a_end_y[W-1], a_end_y} - {a_start_y[W-1], a_start_y};
			bdx_s1  <= {b_end_x[W-1], b_end_x} - {b_start_x[W-1], b_start_x};
			bdy_s1  <= {b_end_y[W-1], b_end_y} - {b_start_y[W-1], b_start_y};
			ox_s1   <= {b_start_x[W-1], b_start_x} - {a_start_x[W-1], a_start_x};
			oy_s1   <= {b_start_y[W-1], b_start_y} - {a_start_y[W-1], a_start_y};

			mode_s2 <= mode_s1;
			a1x_s2  <= a1x_s1;
			a1y_s2  <= a1y_s1;
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			pd0_s2  <= adx_s1 * bdy_s1;
			pd1_s2  <= bdx_s1 * ady_s1;
			pl0_s2  <= ox_s1 * bdy_s1;
			pl1_s2  <= bdx_s1 * oy_s1;
			pm0_s2  <= ox_s1 * ady_s1;
			pm1_s2  <= adx_s1 * oy_s1;

			mode_s3 <= mode_s2;
			a1x_s3  <= a1x_s2;
			a1y_s3  <= a1y_s2;
			adx_s3  <= adx_s2;
			ady_s3  <= ady_s2;
			den_s3  <= {pd0_s2[PP-1], pd0_s2} - {pd1_s2[PP-1], pd1_s2};
			lam_s3  <= {pl0_s2[PP-1], pl0_s2} - {pl1_s2[PP-1], pl1_s2};
			mu_s3   <= {pm0_s2[PP-1], pm0_s2} - {pm1_s2[PP-1], pm1_s2};
		end
	end

	// parameter within [0,1]: numerator between zero and denominator
	always_comb begin
		par = (den_s3 == '0);
		if (den_s3[P-1]) begin
			lam_in = (lam_s3 >= den_s3) && (lam_s3 <= 0);
			mu_in  = (mu_s3 >= den_s3) && (mu_s3 <= 0);
		end else begin
			lam_in = (lam_s3 >= 0) && (lam_s3 <= den_s3);
			mu_in  = (mu_s3 >= 0) && (mu_s3 <= den_s3);
		end
		if (par)
			status = ST_PARALLEL;
		else if (!mode_s3 || (lam_in && mu_in))
			status = ST_HIT;
		else
			status = ST_OUTSIDE;
	end

	assign out_data = {status, par, a1x_s3, a1y_s3, adx_s3, ady_s3, lam_s3, den_s3};

endmodule

@@ hdl/lsi_back.sv @@
// ----------------------------------------------------------------------------
// lsi_back
// Scales the direction by lam, divides by the denominator in a pipelined
// restoring divider, rounds and saturates the crossing point.
// ----------------------------------------------------------------------------
module lsi_back #(
	parameter int COORD_WIDTH = 32,
	localparam int W  = COORD_WIDTH,
	localparam int D  = W + 1,
	localparam int P  = 2 * D + 1,
	localparam int FW = 3 + 2 * W + 2 * D + 2 * P
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lsi_pkg::lsi_qstat_t in_stat,
	input  logic [FW-1:0]       in_data,
	output logic                in_pop,
	output logic                out_valid,
	input  logic                out_full,
	output logic [1:0]          status,
	output logic [W-1:0]        cross_x,
	output logic [W-1:0]        cross_y
);
	import lsi_pkg::*;

	localparam int LM = P - 1;          // |lam| bits
	localparam int H  = W + 1;          // low split of |lam|
	localparam int HM = LM - H;         // high split of |lam|
	localparam int AM = D;              // |direction| bits
	localparam int DM = P - 1;          // |den| bits
	localparam int NM = LM + AM;        // |lam * direction| bits
	localparam int QB = W + 2;          // quotient bits kept
	localparam int SW = W + 4;          // signed offset and sum width

	localparam logic signed [SW-1:0] CMAX = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

	logic en;
	assign en     = !out_full;
	assign in_pop = en && !in_stat.empty;

	// queue head
	logic [1:0]          f_st;
	logic                f_par;
	logic [W-1:0]        f_a1x, f_a1y;
	logic signed [D-1:0] f_adx, f_ady;
	logic signed [P-1:0] f_lam, f_den;
	logic signed [P-1:0] lam_abs, den_abs;
	logic signed [D-1:0] adx_abs, ady_abs;

	assign {f_st, f_par, f_a1x, f_a1y, f_adx, f_ady, f_lam, f_den} = in_data;
	assign lam_abs = f_lam[P-1] ? -f_lam : f_lam;
	assign den_abs = f_den[P-1] ? -f_den : f_den;
	assign adx_abs = f_adx[D-1] ? -f_adx : f_adx;
	assign ady_abs = f_ady[D-1] ? -f_ady : f_ady;

	// b1: magnitudes, b2: partial products, b3: sums, b4: divider entry
	logic          v_s1, v_s2, v_s3;
	logic [1:0]    st_s1, st_s2, st_s3;
	logic          par_s1, par_s2, par_s3;
	logic          sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic [W-1:0]  a1x_s1, a1y_s1, a1x_s2, a1y_s2, a1x_s3, a1y_s3;
	logic [LM-1:0] lam_s1;
	logic [AM-1:0] ax_s1, ay_s1;
	logic [DM-1:0] den_s1, den_s2, den_s3;
	logic [H+AM-1:0]  plx_s2, ply_s2;
	logic [HM+AM-1:0] phx_s2, phy_s2;
	logic [NM-1:0] nx_s3, ny_s3;

	// divider stages, index 0 is the entry
	logic          v_d   [QB+1];
	logic [1:0]    st_d  [QB+1];
	logic          par_d [QB+1];
	logic          sx_d  [QB+1];
	logic          sy_d  [QB+1];
	logic          ovx_d [QB+1];
	logic          ovy_d [QB+1];
	logic [W-1:0]  a1x_d [QB+1];
	logic [W-1:0]  a1y_d [QB+1];
	logic [DM-1:0] den_d [QB+1];
	logic [DM-1:0] rx_d  [QB+1];
	logic [DM-1:0] ry_d  [QB+1];
	logic [QB-1:0] lx_d  [QB+1];
	logic [QB-1:0] ly_d  [QB+1];
	logic [QB-1:0] qx_d  [QB+1];
	logic [QB-1:0] qy_d  [QB+1];

	logic [DM-1:0] rx_n [QB];
	logic [DM-1:0] ry_n [QB];
	logic          bx_n [QB];
	logic          by_n [QB];

	// round stage
	logic                 v_r;
	logic [1:0]           st_r;
	logic                 par_r, ovx_r, ovy_r, sx_r, sy_r;
	logic [W-1:0]         a1x_r, a1y_r;
	logic signed [SW-1:0] ox_r, oy_r;

	logic [NM-QB-1:0] hx, hy;
	assign hx = nx_s3[NM-1:QB];
	assign hy = ny_s3[NM-1:QB];

	always_comb begin
		logic [DM:0] tx;
		logic [DM:0] ty;
		for (int k = 0; k < QB; k++) begin
			tx = {rx_d[k], lx_d[k][QB-1]};
			ty = {ry_d[k], ly_d[k][QB-1]};
			bx_n[k] = (tx >= {1'b0, den_d[k]});
			by_n[k] = (ty >= {1'b0, den_d[k]});
			rx_n[k] = bx_n[k] ? DM'(tx - {1'b0, den_d[k]}) : DM'(tx);
			ry_n[k] = by_n[k] ? DM'(ty - {1'b0, den_d[k]}) : DM'(ty);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_r  <= 1'b0;
			for (int k = 0; k <= QB; k++)
				v_d[k] <= 1'b0;
		end else if (en) begin
			v_s1   <= in_pop;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_d[0] <= v_s3;
			for (int k = 0; k < QB; k++)
				v_d[k+1] <= v_d[k];
			v_r    <= v_d[QB];
		end
	end

	always_ff @(posedge clk) begin
		logic [QB:0] mx;
		logic [QB:0] my;
		if (en) begin
			st_s1  <= f_st;
			par_s1 <= f_par;
			a1x_s1 <= f_a1x;
			a1y_s1 <= f_a1y;
			lam_s1 <= LM'(lam_abs);
			den_s1 <= DM'(den_abs);
			ax_s1  <= adx_abs;
			ay_s1  <= ady_abs;
			sx_s1  <= f_lam[P-1] ^ f_adx[D-1] ^ f_den[P-1];
			sy_s1  <= f_lam[P-1] ^ f_ady[D-1] ^ f_den[P-1];

			st_s2  <= st_s1;
			par_s2 <= par_s1;
			a1x_s2 <= a1x_s1;
			a1y_s2 <= a1y_s1;
			den_s2 <= den_s1;
			sx_s2  <= sx_s1;
			sy_s2  <= sy_s1;
			plx_s2 <= lam_s1[H-1:0] * ax_s1;
			ply_s2 <= lam_s1[H-1:0] * ay_s1;
			phx_s2 <= lam_s1[LM-1:H] * ax_s1;
			phy_s2 <= lam_s1[LM-1:H] * ay_s1;

			st_s3  <= st_s2;
			par_s3 <= par_s2;
			a1x_s3 <= a1x_s2;
			a1y_s3 <= a1y_s2;
			den_s3 <= den_s2;
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;
			nx_s3  <= {phx_s2, H'(0)} + NM'(plx_s2);
			ny_s3  <= {phy_s2, H'(0)} + NM'(ply_s2);

			// quotient too wide for the kept bits: saturate later
			st_d[0]  <= st_s3;
			par_d[0] <= par_s3;
			a1x_d[0] <= a1x_s3;
			a1y_d[0] <= a1y_s3;
			den_d[0] <= den_s3;
			sx_d[0]  <= sx_s3;
			sy_d[0]  <= sy_s3;
			ovx_d[0] <= (DM'(hx) >= den_s3);
			ovy_d[0] <= (DM'(hy) >= den_s3);
			rx_d[0]  <= DM'(hx);
			ry_d[0]  <= DM'(hy);
			lx_d[0]  <= nx_s3[QB-1:0];
			ly_d[0]  <= ny_s3[QB-1:0];
			qx_d[0]  <= '0;
			qy_d[0]  <= '0;

			for (int k = 0; k < QB; k++) begin
				st_d[k+1]  <= st_d[k];
				par_d[k+1] <= par_d[k];
				a1x_d[k+1] <= a1x_d[k];
				a1y_d[k+1] <= a1y_d[k];
				den_d[k+1] <= den_d[k];
				sx_d[k+1]  <= sx_d[k];
				sy_d[k+1]  <= sy_d[k];
				ovx_d[k+1] <= ovx_d[k];
				ovy_d[k+1] <= ovy_d[k];
				rx_d[k+1]  <= rx_n[k];
				ry_d[k+1]  <= ry_n[k];
				lx_d[k+1]  <= {lx_d[k][QB-2:0], 1'b0};
				ly_d[k+1]  <= {ly_d[k][QB-2:0], 1'b0};
				qx_d[k+1]  <= {qx_d[k][QB-2:0], bx_n[k]};
				qy_d[k+1]  <= {qy_d[k][QB-2:0], by_n[k]};
			end

			// round half away from zero on the magnitude, then apply sign
			mx = {1'b0, qx_d[QB]} +
				(QB+1)'({rx_d[QB], 1'b0} >= {1'b0, den_d[QB]});
			my = {1'b0, qy_d[QB]} +
				(QB+1)'({ry_d[QB], 1'b0} >= {1'b0, den_d[QB]});
			st_r  <= st_d[QB];
			par_r <= par_d[QB];
			a1x_r <= a1x_d[QB];
			a1y_r <= a1y_d[QB];
			ovx_r <= ovx_d[QB];
			ovy_r <= ovy_d[QB];
			sx_r  <= sx_d[QB];
			sy_r  <= sy_d[QB];
			ox_r  <= sx_d[QB] ? -$signed({1'b0, mx}) : $signed({1'b0, mx});
			oy_r  <= sy_d[QB] ? -$signed({1'b0, my}) : $signed({1'b0, my});
		end
	end

	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [SW-1:0] sat_x, sat_y;

	assign sum_x = SW'($signed(a1x_r)) + ox_r;
	assign sum_y = SW'($signed(a1y_r)) + oy_r;

	always_comb begin
		if (ovx_r)
			sat_x = sx_r ? CMIN : CMAX;
		else if (sum_x > CMAX)
			sat_x = CMAX;
		else if (sum_x < CMIN)
			sat_x = CMIN;
		else
			sat_x = sum_x;
		if (ovy_r)
			sat_y = sy_r ? CMIN : CMAX;
		else if (sum_y > CMAX)
			sat_y = CMAX;
		else if (sum_y < CMIN)
			sat_y = CMIN;
		else
			sat_y = sum_y;
	end

	assign out_valid = v_r && en;
	assign status    = st_r;
	assign cross_x   = par_r ? '0 : sat_x[W-1:0];
	assign cross_y   = par_r ? '0 : sat_y[W-1:0];

endmodule

@@ hdl/line_segment_intersection.sv @@
// ----------------------------------------------------------------------------
// line_segment_intersection
// Crossing point of two 2D lines or segments in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one beat per clock while full is low and returns one result beat per
// input beat, in order. The front part (3 stages) forms the denominator and
// both numerators with 33x33 multipliers and classifies the beat; a 4-entry
// queue decouples it from the back part, which runs 4 product stages, a
// restoring divider of COORD_WIDTH+2 stages (one quotient bit per stage) and a
// rounding stage, feeding a 2-entry result queue. The divider depth dominates
// the delay from push to empty going low. Either side stalls on its own while
// the other keeps moving.
module line_segment_intersection #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   mode,
	input  logic [COORD_WIDTH-1:0] a_start_x,
	input  logic [COORD_WIDTH-1:0] a_start_y,
	input  logic [COORD_WIDTH-1:0] a_end_x,
	input  logic [COORD_WIDTH-1:0] a_end_y,
	input  logic [COORD_WIDTH-1:0] b_start_x,
	input  logic [COORD_WIDTH-1:0] b_start_y,
	input  logic [COORD_WIDTH-1:0] b_end_x,
	input  logic [COORD_WIDTH-1:0] b_end_y,
	output logic                   empty,
	input  logic                   pop,
	output logic [1:0]             status,
	output logic [COORD_WIDTH-1:0] cross_x,
	output logic [COORD_WIDTH-1:0] cross_y
);
	import lsi_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int D  = W + 1;
	localparam int P  = 2 * D + 1;
	localparam int FW = 3 + 2 * W + 2 * D + 2 * P;
	localparam int OW = 2 + 2 * W;

	logic          fe_valid;
	logic [FW-1:0] fe_data;
	logic [FW-1:0] mq_data;
	lsi_qstat_t    mq_stat;
	logic          mq_pop;
	logic          be_valid;
	logic [1:0]    be_status;
	logic [W-1:0]  be_x, be_y;
	lsi_qstat_t    oq_stat;

	lsi_front #(.COORD_WIDTH(W)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_full   (full),
		.mode      (mode),
		.a_start_x (a_start_x),
		.a_start_y (a_start_y),
		.a_end_x   (a_end_x),
		.a_end_y   (a_end_y),
		.b_start_x (b_start_x),
		.b_start_y (b_start_y),
		.b_end_x   (b_end_x),
		.b_end_y   (b_end_y),
		.out_valid (fe_valid),
		.out_full  (mq_stat.full),
		.out_data  (fe_data)
	);

	lsi_fifo #(.WIDTH(FW), .DEPTH(4)) u_midq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fe_valid),
		.wr_data (fe_data),
		.rd      (mq_pop),
		.rd_data (mq_data),
		.stat    (mq_stat)
	);

	lsi_back #(.COORD_WIDTH(W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_stat   (mq_stat),
		.in_data   (mq_data),
		.in_pop    (mq_pop),
		.out_valid (be_valid),
		.out_full  (oq_stat.full),
		.status    (be_status),
		.cross_x   (be_x),
		.cross_y   (be_y)
	);

	logic [OW-1:0] oq_data;

	lsi_fifo #(.WIDTH(OW), .DEPTH(2)) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (be_valid),
		.wr_data ({be_status, be_x, be_y}),
		.rd      (pop),
		.rd_data (oq_data),
		.stat    (oq_stat)
	);

	assign empty                      = oq_stat.empty;
	assign {status, cross_x, cross_y} = oq_data;

endmodule

@@ tb/tb_line_segment_intersection.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_segment_intersection
// Directed and randomized queue-level test of the 2D line and segment crossing block.
// ----------------------------------------------------------------------------
// Line pairs are pushed from a pending queue under four idling phases. Each
// accepted beat is run through an exact wide-integer crossing calculation, and
// every popped result is compared with the oldest predicted crossing.
module tb_line_segment_intersection;
	import lsi_pkg::*;

	localparam int CW = 32;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic          mode;
		logic [CW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
	} line_pair_t;

	typedef struct {
		logic [1:0]    status;
		logic [CW-1:0] x, y;
	} crossing_t;

	logic clk, arst_n, push, full, empty, pop, mode;
	logic [CW-1:0] a_start_x, a_start_y, a_end_x, a_end_y;
	logic [CW-1:0] b_start_x, b_start_y, b_end_x, b_end_y;
	logic [1:0] status;
	logic [CW-1:0] cross_x, cross_y;

	line_pair_t pending_pairs[$];
	crossing_t  expected_crossings[$];
	int send_idle, recv_stall, mismatches, quiet_cycles;

	line_segment_intersection #(.COORD_WIDTH(CW)) dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [255:0] widen(logic [CW-1:0] v);
		return {{(256-CW){v[CW-1]}}, v};
	endfunction

	// round n/d to nearest, ties away from zero
	function automatic logic signed [255:0] div_round(logic signed [255:0] n,
			logic signed [255:0] d);
		logic signed [255:0] un, ud, q, r;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = un / ud;
		r = un % ud;
		if (2 * r >= ud) q = q + 1;
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic logic [CW-1:0] clamp_coord(logic signed [255:0] v);
		logic signed [255:0] hi, lo;
		hi = (256'sd1 <<< (CW-1)) - 1;
		lo = -(256'sd1 <<< (CW-1));
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[CW-1:0];
	endfunction

	function automatic logic ratio_in_unit(logic signed [255:0] num,
			logic signed [255:0] den);
		if (den < 0) return num >= den && num <= 0;
		return num >= 0 && num <= den;
	endfunction

	function automatic crossing_t compute_crossing(line_pair_t p);
		logic signed [255:0] adx, ady, bdx, bdy, ox, oy, den, lam, mu;
		crossing_t c;
		adx = widen(p.ax2) - widen(p.ax1);
		ady = widen(p.ay2) - widen(p.ay1);
		bdx = widen(p.bx2) - widen(p.bx1);
		bdy = widen(p.by2) - widen(p.by1);
		ox = widen(p.bx1) - widen(p.ax1);
		oy = widen(p.by1) - widen(p.ay1);
		den = adx * bdy - bdx * ady;
		if (den == 0) begin
			c.status = ST_PARALLEL;
			c.x = '0;
			c.y = '0;
			return c;
		end
		lam = ox * bdy - bdx * oy;
		mu = ox * ady - adx * oy;
		c.x = clamp_coord(widen(p.ax1) + div_round(lam * adx, den));
		c.y = clamp_coord(widen(p.ay1) + div_round(lam * ady, den));
		if (!p.mode || (ratio_in_unit(lam, den) && ratio_in_unit(mu, den)))
			c.status = ST_HIT;
		else
			c.status = ST_OUTSIDE;
		return c;
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(2047)) - 1024;
			default: return ($signed($urandom_range(255)) - 128) <<< 16;
		endcase
	endfunction

	function automatic line_pair_t make_pair(logic m, int ax1, int ay1, int ax2, int ay2,
			int bx1, int by1, int bx2, int by2);
		line_pair_t p;
		p.mode = m;
		p.ax1 = ax1; p.ay1 = ay1; p.ax2 = ax2; p.ay2 = ay2;
		p.bx1 = bx1; p.by1 = by1; p.bx2 = bx2; p.by2 = by2;
		return p;
	endfunction

	function automatic line_pair_t rand_pair();
		line_pair_t p;
		int k;
		p.mode = $urandom_range(1);
		p.ax1 = rand_coord(); p.ay1 = rand_coord(); p.ax2 = rand_coord();
		p.ay2 = rand_coord(); p.bx1 = rand_coord(); p.by1 = rand_coord();
		if ($urandom_range(9) == 0) begin
			// parallel: B direction is a multiple of A direction
			k = $signed($urandom_range(6)) - 3;
			p.bx2 = p.bx1 + k * (p.ax2 - p.ax1);
			p.by2 = p.by1 + k * (p.ay2 - p.ay1);
		end else begin
			p.bx2 = rand_coord();
			p.by2 = rand_coord();
		end
		return p;
	endfunction

	task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// driver: advance to the next pair once the current beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 0;
		end else begin
			if (push && !full) expected_crossings.push_back(compute_crossing(
				'{mode, a_start_x, a_start_y, a_end_x, a_end_y,
				  b_start_x, b_start_y, b_end_x, b_end_y}));
			if (!push || !full) begin
				if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle) begin
					line_pair_t p;
					p = pending_pairs.pop_front();
					{mode, a_start_x, a_start_y, a_end_x, a_end_y} <=
						{p.mode, p.ax1, p.ay1, p.ax2, p.ay2};
					{b_start_x, b_start_y, b_end_x, b_end_y} <= {p.bx1, p.by1, p.bx2, p.by2};
					push <= 1;
				end else begin
					push <= 0;
				end
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
			quiet_cycles <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_crossings.size() == 0) begin
					report_mismatch("unexpected beat", CW'(status), '0);
				end else begin
					crossing_t c;
					c = expected_crossings.pop_front();
					if (status !== c.status)
						report_mismatch("status", CW'(status), CW'(c.status));
					if (cross_x !== c.x) report_mismatch("cross_x", cross_x, c.x);
					if (cross_y !== c.y) report_mismatch("cross_y", cross_y, c.y);
				end
			end
			pop <= $urandom_range(99) >= recv_stall;
			quiet_cycles <= ((push && !full) || (pop && !empty)) ? 0 : quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int send_pct[4];
		int recv_pct[4];
		int max_c, min_c;
		send_pct = '{0, 64, 0, 23};
		recv_pct = '{0, 0, 64, 23};
		max_c = 32'h7fffffff;
		min_c = 32'h80000000;
		mismatches = 0;
		send_idle = 0;
		recv_stall = 0;
		{mode, a_start_x, a_start_y, a_end_x, a_end_y} = '0;
		{b_start_x, b_start_y, b_end_x, b_end_y} = '0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// crossing X in both modes, endpoint touch, outside, parallel, degenerate
		pending_pairs.push_back(make_pair(0, 0, 0, 65536, 65536, 0, 65536, 65536, 0));
		pending_pairs.push_back(make_pair(1, 0, 0, 65536, 65536, 0, 65536, 65536, 0));
		pending_pairs.push_back(make_pair(1, 0, 0, 65536, 0, 65536, 0, 65536, 65536));
		pending_pairs.push_back(make_pair(1, 0, 0, 65536, 0, 65536, -65536, 65536, 0));
		pending_pairs.push_back(make_pair(1, 0, 0, 65536, 0, 131072, -65536, 131072, 65536));
		pending_pairs.push_back(make_pair(0, 0, 0, 65536, 0, 131072, -65536, 131072, 65536));
		pending_pairs.push_back(make_pair(1, 0, 0, 65536, 0, 65537, -65536, 65537, 65536));
		pending_pairs.push_back(make_pair(1, 0, 0, 65536, 0, 0, 65536, 65536, 65536));
		pending_pairs.push_back(make_pair(1, 0, 0, 65536, 0, 0, 0, 65536, 0));
		pending_pairs.push_back(make_pair(1, 5, 5, 5, 5, 0, 0, 9, 9));
		pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
		// half-LSB ties in the rounding
		pending_pairs.push_back(make_pair(0, 0, 0, 1, 1, 0, 1, 2, -1));
		pending_pairs.push_back(make_pair(0, 0, 0, -1, -1, 0, -1, -2, 1));
		pending_pairs.push_back(make_pair(0, 0, 0, 1, 3, 0, 2, 2, 0));
		// extremes and saturation
		pending_pairs.push_back(make_pair(0, min_c, min_c, max_c, max_c,
			min_c, max_c, max_c, min_c));
		pending_pairs.push_back(make_pair(1, min_c, min_c, max_c, max_c,
			min_c, max_c, max_c, min_c));
		pending_pairs.push_back(make_pair(0, max_c, max_c, max_c - 1, max_c,
			min_c, min_c, min_c + 1, min_c + 1));
		pending_pairs.push_back(make_pair(0, min_c, min_c, min_c + 1, min_c,
			max_c, max_c, max_c - 1, max_c - 1));
		pending_pairs.push_back(make_pair(0, 0, 0, 1, 1, 0, 1, 1, 1));
		pending_pairs.push_back(make_pair(1, max_c, min_c, min_c, max_c,
			min_c, min_c, max_c, max_c));
		pending_pairs.push_back(make_pair(1, -1, -1, 1, 1, 1, -1, -1, 1));

		for (int ph = 0; ph < 4; ph++) begin
			send_idle = send_pct[ph];
			recv_stall = recv_pct[ph];
			repeat (135) pending_pairs.push_back(rand_pair());
			wait (pending_pairs.size() == 0 && !push);
			wait (expected_crossings.size() == 0);
		end

		repeat (80) @(posedge clk);
		if (mismatches == 0 && expected_crossings.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
